// ----- sv/aeske_pkg.sv -----
// AES-128 key expansion package: S-box table, word helpers, round constants
// and the stage record passed between chain cells. No dependencies.
`default_nettype none

package aeske_pkg;

    localparam int ROUNDS   = 11;
    localparam int KEY_W    = 128;
    localparam int WORD_W   = 32;
    localparam int ROUND_W  = 4;
    localparam int IN_W     = 128;
    localparam int OUT_W    = 136;
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // RotWord then SubWord
    function automatic logic [WORD_W-1:0] rot_sub(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = {w[23:0], w[31:24]};
        return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
    endfunction

    // round constant byte for the cell that builds round key idx+1
    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h01;
            4'd1:    c = 8'h02;
            4'd2:    c = 8'h04;
            4'd3:    c = 8'h08;
            4'd4:    c = 8'h10;
            4'd5:    c = 8'h20;
            4'd6:    c = 8'h40;
            4'd7:    c = 8'h80;
            4'd8:    c = 8'h1b;
            4'd9:    c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/aeske_cell.sv -----
// One chain cell: holds a round key and hands the next round key to its
// neighbor on every shift. Depends on aeske_pkg.
`default_nettype none

module aeske_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire logic [7:0]        rcon,
    input  wire aeske_pkg::stage_t prev,
    output aeske_pkg::stage_t      held,
    output aeske_pkg::stage_t      hand
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [aeske_pkg::KEY_W-1:0]     key_reg;
    logic [aeske_pkg::WORD_W-1:0]    w0, w1, w2, w3, t, n0, n1, n2, n3;

    assign valid_next = shift ? prev.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift && prev.valid)
        begin
            key_reg <= prev.key;
        end
    end

    assign w0 = key_reg[127:96];
    assign w1 = key_reg[95:64];
    assign w2 = key_reg[63:32];
    assign w3 = key_reg[31:0];
    assign t  = aeske_pkg::rot_sub(w3) ^ {rcon, 24'h0};
    assign n0 = w0 ^ t;
    assign n1 = w1 ^ n0;
    assign n2 = w2 ^ n1;
    assign n3 = w3 ^ n2;

    assign held.valid = valid_reg;
    assign held.key   = key_reg;
    assign hand.valid = valid_reg;
    assign hand.key   = {n0, n1, n2, n3};

endmodule

`default_nettype wire

// ----- sv/aes128_key_expansion.sv -----
// AES-128 key expansion top: ten expansion cells in a chain, a final round
// holding register and the output register. Depends on aeske_pkg, aeske_cell.
//
//  channel  dir  tdata                                        tuser/tlast
//  s_axis   in   [63:0] key_high, [127:64] key_low            -
//  m_axis   out  [3:0] round_index, [35:4] word_a,            tlast = final_round
//                [67:36] word_b, [99:68] word_c, [131:100] word_d
//
// One key gives eleven transactions, one per cycle while m_axis_tready is high.
// A new key is taken in the cycle round 10 moves to the output, once no cell
// holds a round key any more. The key walks one cell per cycle, each cell
// producing the next round key. A stall on m_axis freezes the whole chain.
// Reset clears all valid bits; the key and round index registers are not reset.
`default_nettype none

module aes128_key_expansion (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [aeske_pkg::IN_W-1:0]    s_axis_tdata,   // key_high, key_low
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [aeske_pkg::OUT_W-1:0]        m_axis_tdata,   // round_index, word_a..word_d
    output logic                               m_axis_tlast    // final_round
);

    localparam int CELLS = aeske_pkg::ROUNDS - 1;

    aeske_pkg::stage_t                 prev_s [CELLS];
    aeske_pkg::stage_t                 held_s [CELLS];
    aeske_pkg::stage_t                 hand_s [CELLS];

    logic                              shift;
    logic                              load;
    logic                              chain_busy;
    logic [aeske_pkg::ROUNDS-1:0]      vec;
    logic [aeske_pkg::KEY_W-1:0]       key_at [aeske_pkg::ROUNDS];

    logic                              fin_valid_reg;
    logic                              fin_valid_next;
    logic [aeske_pkg::KEY_W-1:0]       fin_key_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [aeske_pkg::ROUND_W-1:0]     out_round_reg;
    logic [aeske_pkg::ROUND_W-1:0]     out_round_next;
    logic [aeske_pkg::KEY_W-1:0]       out_key_reg;
    logic [aeske_pkg::KEY_W-1:0]       out_key_next;

    assign shift         = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = shift && !chain_busy;
    assign load          = s_axis_tvalid && s_axis_tready;

    assign prev_s[0].valid = load;
    assign prev_s[0].key   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        if (g > 0)
        begin : g_link
            assign prev_s[g] = hand_s[g-1];
        end
        aeske_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .rcon  (aeske_pkg::rcon(aeske_pkg::ROUND_W'(g))),
            .prev  (prev_s[g]),
            .held  (held_s[g]),
            .hand  (hand_s[g])
        );
        assign vec[g]    = held_s[g].valid;
        assign key_at[g] = held_s[g].key;
    end

    assign vec[CELLS]    = fin_valid_reg;
    assign key_at[CELLS] = fin_key_reg;
    assign chain_busy    = |vec[CELLS-1:0];
    assign fin_valid_next = shift ? hand_s[CELLS-1].valid : fin_valid_reg;

    always_comb
    begin
        out_round_next = '0;
        out_key_next   = '0;
        for (int i = 0; i < aeske_pkg::ROUNDS; i++)
        begin
            if (vec[i])
            begin
                out_round_next = out_round_next | aeske_pkg::ROUND_W'(i);
                out_key_next   = out_key_next | key_at[i];
            end
        end
        out_valid_next = shift ? (|vec) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift && hand_s[CELLS-1].valid)
        begin
            fin_key_reg <= hand_s[CELLS-1].key;
        end
        if (shift)
        begin
            out_round_reg <= out_round_next;
            out_key_reg   <= out_key_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = (out_round_reg == aeske_pkg::LAST_ROUND);
    assign m_axis_tdata  = {4'h0, out_key_reg[31:0], out_key_reg[63:32],
                            out_key_reg[95:64], out_key_reg[127:96], out_round_reg};

    a_one_key: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec))
        else $error("more than one round key in the chain");

    a_load_enters: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> held_s[0].valid)
        else $error("accepted key did not enter the first cell");

    a_round_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && out_round_reg == $past(out_round_reg) + 4'd1))
        else $error("round keys out of sequence");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for aes128_key_expansion: streams 128-bit keys in and
// checks all eleven round keys per key against a local AES-128 key schedule.
// Depends on aeske_pkg (port widths) and the aes128_key_expansion RTL.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_KEYS  = 400;
    localparam int CALM_TAIL    = 60;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [3:0]  round_index;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic        final_round;
    } round_key_t;

    typedef struct packed {
        logic [63:0]  key_high;
        logic [63:0]  key_low;
        logic         has_last;
        logic [127:0] last_key;
    } key_vector_t;

    localparam int VECTOR_COUNT = 10;

    // the round 10 keys given for the first three vectors are published values
    key_vector_t key_table [VECTOR_COUNT] = '{
        '{64'h0000000000000000, 64'h0000000000000000, 1'b1,
          128'hb4ef5bcb3e92e21123e951cf6f8f188e},
        '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
          128'hd014f9a8c9ee2589e13f0cc8b6630ca6},
        '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
          128'h13111d7fe3944a17f307a78b4d2b30c5},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
        '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 128'h0},
        '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 128'h0},
        '{64'h8000000000000000, 64'h0000000000000000, 1'b0, 128'h0},
        '{64'h0000000000000000, 64'h0000000000000001, 1'b0, 128'h0},
        '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 128'h0},
        '{64'hffffffff00000000, 64'h00000000ffffffff, 1'b0, 128'h0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [aeske_pkg::IN_W-1:0]     s_axis_tdata = '0;    // key_high, key_low
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [aeske_pkg::OUT_W-1:0]    m_axis_tdata;         // round_index, word_a..word_d
    logic                           m_axis_tlast;         // final_round

    logic [7:0]  sbox_lut [256];
    logic [7:0]  rcon_lut [10];
    round_key_t  round_keys_due [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          gap_odds = 0;
    bit          sink_calm = 1'b0;
    bit          quiet_tail = 1'b0;

    aes128_key_expansion dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [31:0] rot_sub_word(input logic [31:0] v);
        logic [31:0] r;
        r = {v[23:0], v[31:24]};
        return {sbox_lut[r[31:24]], sbox_lut[r[23:16]], sbox_lut[r[15:8]], sbox_lut[r[7:0]]};
    endfunction

    // expands one key and queues its eleven round keys
    function automatic void expand_key(input logic [63:0] key_high, input logic [63:0] key_low,
                                       input logic use_known, input logic [127:0] known_last);
        logic [31:0] w [44];
        logic [31:0] t;
        round_key_t  rk;
        w[0] = key_high[63:32];
        w[1] = key_high[31:0];
        w[2] = key_low[63:32];
        w[3] = key_low[31:0];
        for (int n = 4; n < 44; n++)
        begin
            t = w[n-1];
            if (n % 4 == 0)
                t = rot_sub_word(t) ^ {rcon_lut[n/4 - 1], 24'h0};
            w[n] = w[n-4] ^ t;
        end
        for (int r = 0; r < aeske_pkg::ROUNDS; r++)
        begin
            rk.round_index = 4'(r);
            rk.word_a      = w[4*r];
            rk.word_b      = w[4*r + 1];
            rk.word_c      = w[4*r + 2];
            rk.word_d      = w[4*r + 3];
            rk.final_round = (r == aeske_pkg::ROUNDS - 1);
            if (use_known && r == aeske_pkg::ROUNDS - 1)
                {rk.word_a, rk.word_b, rk.word_c, rk.word_d} = known_last;
            round_keys_due.push_back(rk);
        end
    endfunction

    task automatic send_key(input logic [63:0] key_high, input logic [63:0] key_low,
                            input logic use_known, input logic [127:0] known_last);
        if (!quiet_tail && gap_odds != 0 && $urandom_range(0, 7) < gap_odds)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key_low, key_high};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expand_key(key_high, key_low, use_known, known_last);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (round_keys_due.size() != 0)
            @(posedge clk);
    endtask

    // result sink with bursty backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!quiet_tail && !sink_calm && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 12);
        end
        else
            m_axis_tready <= 1'b1;
        if ($urandom_range(0, 127) == 0)
            sink_calm <= !sink_calm;
    end

    always @(posedge clk)
    begin
        round_key_t got;
        round_key_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.round_index = m_axis_tdata[3:0];
            got.word_a      = m_axis_tdata[35:4];
            got.word_b      = m_axis_tdata[67:36];
            got.word_c      = m_axis_tdata[99:68];
            got.word_d      = m_axis_tdata[131:100];
            got.final_round = m_axis_tlast;
            if (round_keys_due.size() == 0)
            begin
                $error("unexpected round key transaction: round_index %0d", got.round_index);
                mismatch_count++;
            end
            else
            begin
                want = round_keys_due.pop_front();
                if (got.round_index !== want.round_index)
                begin
                    $error("round_index: expected %0d, got %0d", want.round_index,
                           got.round_index);
                    mismatch_count++;
                end
                if (got.word_a !== want.word_a)
                begin
                    $error("word_a: expected %h, got %h", want.word_a, got.word_a);
                    mismatch_count++;
                end
                if (got.word_b !== want.word_b)
                begin
                    $error("word_b: expected %h, got %h", want.word_b, got.word_b);
                    mismatch_count++;
                end
                if (got.word_c !== want.word_c)
                begin
                    $error("word_c: expected %h, got %h", want.word_c, got.word_c);
                    mismatch_count++;
                end
                if (got.word_d !== want.word_d)
                begin
                    $error("word_d: expected %h, got %h", want.word_d, got.word_d);
                    mismatch_count++;
                end
                if (got.final_round !== want.final_round)
                begin
                    $error("final_round: expected %0b, got %0b", want.final_round,
                           got.final_round);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0]  inv;
        logic [63:0] hi;
        logic [63:0] lo;
        int          bit_pos;
        logic [7:0]  fill;

        for (int v = 0; v < 256; v++)
        begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++)
                inv = gf_mul(inv, 8'(v));
            sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
        rcon_lut[0] = 8'h01;
        for (int i = 1; i < 10; i++)
            rcon_lut[i] = gf_mul(rcon_lut[i-1], 8'h02);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        gap_odds = 2;
        foreach (key_table[i])
            send_key(key_table[i].key_high, key_table[i].key_low,
                     key_table[i].has_last, key_table[i].last_key);
        wait_drained();

        for (int n = 0; n < RANDOM_KEYS; n++)
        begin
            if (n % 32 == 0)
                gap_odds = $urandom_range(0, 3);
            if (n == RANDOM_KEYS - CALM_TAIL)
                quiet_tail = 1'b1;
            if (!quiet_tail && $urandom_range(0, 99) == 0)
                wait_drained();
            case ($urandom_range(0, 9))
                0:
                begin
                    bit_pos = $urandom_range(0, 127);
                    {hi, lo} = 128'h1 << bit_pos;
                end
                1:
                begin
                    fill = 8'($urandom);
                    hi = {8{fill}};
                    lo = {8{fill}};
                end
                default:
                begin
                    hi = {$urandom, $urandom};
                    lo = {$urandom, $urandom};
                end
            endcase
            send_key(hi, lo, 1'b0, 128'h0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && round_keys_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
